@@ hdl/kpv_pkg.sv @@
// ----------------------------------------------------------------------------
// kpv_pkg: shared types and constants of the keypad PIN verifier
// Key codes, outcome and verdict codes, and configuration register indexes.
// ----------------------------------------------------------------------------
package kpv_pkg;

    // ASCII key codes
    localparam logic [7:0] KEY_0 = 8'h30;
    localparam logic [7:0] KEY_9 = 8'h39;
    localparam logic [7:0] KEY_B = 8'h42;
    localparam logic [7:0] KEY_C = 8'h43;
    localparam logic [7:0] KEY_D = 8'h44;

    localparam logic [15:0] HOLD_RESET = 16'd2000;
    localparam logic [15:0] CNT_MAX    = 16'hFFFF;

    // input word kinds (tuser)
    localparam logic MODE_KEY  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // configuration register indexes
    localparam logic REG_PIN  = 1'b0;
    localparam logic REG_HOLD = 1'b1;

    typedef enum logic [1:0] {
        OUT_ENTERING = 2'd0,
        OUT_HOLDING  = 2'd1,
        OUT_UNLOCK   = 2'd2,
        OUT_CANCEL   = 2'd3
    } outcome_t;

    typedef enum logic [1:0] {
        MSG_NONE       = 2'd0,
        MSG_CORRECT    = 2'd1,
        MSG_WRONG      = 2'd2,
        MSG_INCOMPLETE = 2'd3
    } message_t;

    typedef struct packed {
        logic [15:0] entry_digits;
        logic [2:0]  digit_count;
        message_t    message;
        outcome_t    outcome;
    } result_t;

endpackage

@@ hdl/keypad_pin_verifier.sv @@
// ----------------------------------------------------------------------------
// keypad_pin_verifier: keypad PIN entry and check with a timed verdict hold
// Collects digit keys, checks them against the stored PIN on 'C' and holds
// the verdict for a programmable number of millisecond ticks.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one word per key press or millisecond tick:
//   s_tuser selects the kind (0 key, 1 tick), s_tdata holds the ASCII key.
//   Every accepted word produces exactly one result word on the m_ stream,
//   reporting outcome, verdict message, digit count and the BCD entry.
//   The entry state and the result register are updated at the accepting
//   edge, so a result is valid in the cycle after its word is accepted.
//   Throughput is one word per cycle: s_tready stays high while the result
//   register is empty or being drained in the same cycle. When the receiver
//   stalls, the result holds in the output register and s_tready drops until
//   it is taken.
//   The APB port sets stored_pin (address 0) and hold_ticks (address 4);
//   write it only while no result is outstanding.
//   Reset (aresetn low, synchronous) clears the entry, ends any hold, empties
//   the result register and loads stored_pin = 0, hold_ticks = 2000.
// ----------------------------------------------------------------------------
module keypad_pin_verifier #(
    parameter int PIN_DIGITS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] key_code
    input  logic        s_tuser,   // [0] mode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [1:0] outcome, [3:2] message,
                                   // [6:4] digit_count, [22:7] entry_digits
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import kpv_pkg::*;

    localparam int CNT_W  = $clog2(PIN_DIGITS + 1);
    localparam int PACK_W = 4 * PIN_DIGITS;
    localparam int EXT_W  = (PACK_W > 16) ? PACK_W : 16;
    localparam int CEXT_W = (CNT_W > 3) ? CNT_W : 3;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PIN_DIGITS);

    // configuration registers
    logic [15:0] pin_reg;
    logic [15:0] hold_ticks_reg;

    // entry state
    logic [3:0]       digit_reg [PIN_DIGITS];
    logic [3:0]       digit_next [PIN_DIGITS];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             holding_reg, holding_next;
    logic [15:0]      hold_cnt_reg, hold_cnt_next;
    message_t         verdict_reg, verdict_next;

    // result register
    logic    out_valid_reg;
    result_t out_reg, out_next;

    logic              accept;
    logic              cfg_wr;
    logic [15:0]       limit;
    logic [15:0]       hold_inc;
    logic [PACK_W-1:0] cur_vec, new_vec;
    logic [EXT_W-1:0]  cur_ext, new_ext;
    logic [CEXT_W-1:0] cnt_ext;
    outcome_t          outcome;
    message_t          message;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg};

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_HOLD) ? {16'b0, hold_ticks_reg} : {16'b0, pin_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pin_reg        <= '0;
            hold_ticks_reg <= HOLD_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_HOLD) begin
                hold_ticks_reg <= pwdata[15:0];
            end else begin
                pin_reg <= pwdata[15:0];
            end
        end
    end

    // pack entry, first digit in the top nibble
    always_comb begin
        for (int i = 0; i < PIN_DIGITS; i++) begin
            cur_vec[4*(PIN_DIGITS-1-i) +: 4] = digit_reg[i];
            new_vec[4*(PIN_DIGITS-1-i) +: 4] = digit_next[i];
        end
    end

    assign cur_ext  = EXT_W'(cur_vec);
    assign new_ext  = EXT_W'(new_vec);
    assign cnt_ext  = CEXT_W'(cnt_next);
    assign limit    = (hold_ticks_reg == 16'd0) ? 16'd1 : hold_ticks_reg;
    assign hold_inc = (hold_cnt_reg == CNT_MAX) ? hold_cnt_reg : hold_cnt_reg + 16'd1;

    always_comb begin
        for (int i = 0; i < PIN_DIGITS; i++) begin
            digit_next[i] = digit_reg[i];
        end
        cnt_next      = cnt_reg;
        holding_next  = holding_reg;
        hold_cnt_next = hold_cnt_reg;
        verdict_next  = verdict_reg;
        outcome       = OUT_ENTERING;
        message       = MSG_NONE;

        if (holding_reg) begin
            outcome = OUT_HOLDING;
            message = verdict_reg;
            if (s_tuser == MODE_TICK) begin
                hold_cnt_next = hold_inc;
                if (hold_inc >= limit) begin
                    // hold over: clear entry and report
                    outcome       = (verdict_reg == MSG_CORRECT) ? OUT_UNLOCK : OUT_ENTERING;
                    message       = MSG_NONE;
                    holding_next  = 1'b0;
                    hold_cnt_next = '0;
                    verdict_next  = MSG_NONE;
                    cnt_next      = '0;
                    for (int i = 0; i < PIN_DIGITS; i++) begin
                        digit_next[i] = '0;
                    end
                end
            end
        end else if (s_tuser == MODE_KEY) begin
            case (s_tdata) inside
                [KEY_0:KEY_9]: begin
                    if (cnt_reg < CNT_FULL) begin
                        for (int i = 0; i < PIN_DIGITS; i++) begin
                            if (cnt_reg == CNT_W'(i)) begin
                                digit_next[i] = 4'(s_tdata - KEY_0);
                            end
                        end
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                KEY_D: begin
                    if (cnt_reg != '0) begin
                        for (int i = 0; i < PIN_DIGITS; i++) begin
                            if (cnt_reg == CNT_W'(i + 1)) begin
                                digit_next[i] = '0;
                            end
                        end
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
                KEY_B: begin
                    cnt_next = '0;
                    for (int i = 0; i < PIN_DIGITS; i++) begin
                        digit_next[i] = '0;
                    end
                    outcome = OUT_CANCEL;
                end
                KEY_C: begin
                    if (cnt_reg == CNT_FULL) begin
                        verdict_next = (cur_ext == EXT_W'(pin_reg)) ? MSG_CORRECT : MSG_WRONG;
                    end else begin
                        verdict_next = MSG_INCOMPLETE;
                    end
                    holding_next  = 1'b1;
                    hold_cnt_next = '0;
                    outcome       = OUT_HOLDING;
                    message       = verdict_next;
                end
                default: begin
                end
            endcase
        end

        out_next.outcome      = outcome;
        out_next.message      = message;
        out_next.digit_count  = cnt_ext[2:0];
        out_next.entry_digits = new_ext[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PIN_DIGITS; i++) begin
                digit_reg[i] <= '0;
            end
            cnt_reg       <= '0;
            holding_reg   <= 1'b0;
            hold_cnt_reg  <= '0;
            verdict_reg   <= MSG_NONE;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                for (int i = 0; i < PIN_DIGITS; i++) begin
                    digit_reg[i] <= digit_next[i];
                end
                cnt_reg       <= cnt_next;
                holding_reg   <= holding_next;
                hold_cnt_reg  <= hold_cnt_next;
                verdict_reg   <= verdict_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= out_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_FULL)
        else $error("digit count beyond PIN length");

    a_hold_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        holding_reg |-> verdict_reg != MSG_NONE)
        else $error("hold without a verdict");

    a_idle_counter: assert property (@(posedge aclk) disable iff (!aresetn)
        !holding_reg |-> hold_cnt_reg == 16'd0 && verdict_reg == MSG_NONE)
        else $error("hold counter or verdict left over outside a hold");

    a_key_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && holding_reg && s_tuser == MODE_KEY |=> $stable(cnt_reg) && holding_reg)
        else $error("key during hold changed the entry");

    a_unlock_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_reg.outcome == OUT_UNLOCK |->
            out_reg.digit_count == 3'd0 && out_reg.entry_digits == 16'd0)
        else $error("unlock result with a nonempty entry");
`endif

endmodule
